@@ rtl/bumc_pkg.sv @@
// Package for the button UI mode controller: event and mode codes,
// register indexes, channel word types and the shared tick summary type. No dependencies.
package bumc_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int MAX_EV = 10;
	localparam int TICK_Q_DEPTH = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUB = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIFI = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;

	localparam int B_REC = 0;
	localparam int B_PLAY = 1;
	localparam int B_TRACK = 2;
	localparam int B_MODE = 3;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_REC = 3'd1;
	localparam logic [2:0] M_PLAY = 3'd2;
	localparam logic [2:0] M_PAUSE = 3'd3;
	localparam logic [2:0] M_PAIR = 3'd4;
	localparam logic [2:0] M_DUB = 3'd5;
	localparam logic [2:0] M_WIFI = 3'd6;
	localparam logic [2:0] M_SLEEP = 3'd7;

	localparam logic [3:0] E_NONE = 4'd0;
	localparam logic [3:0] E_RSTART = 4'd1;
	localparam logic [3:0] E_RSTOP = 4'd2;
	localparam logic [3:0] E_RREFUSE = 4'd3;
	localparam logic [3:0] E_PLAY = 4'd4;
	localparam logic [3:0] E_PAUSE = 4'd5;
	localparam logic [3:0] E_RESUME = 4'd6;
	localparam logic [3:0] E_STOP = 4'd7;
	localparam logic [3:0] E_TRACK = 4'd8;
	localparam logic [3:0] E_PAIR = 4'd9;
	localparam logic [3:0] E_DUB = 4'd10;
	localparam logic [3:0] E_WIFI = 4'd11;
	localparam logic [3:0] E_SLEEP = 4'd12;
	localparam logic [3:0] E_WAKE = 4'd13;

	// Input word of one tick.
	typedef struct packed {
		logic [31:0] now_ms;
		logic [3:0]  raw_buttons;
		logic        tab_present;
	} tick_word_t;

	// Result word: one per event, or a single none word for a quiet tick.
	typedef struct packed {
		logic [3:0] event_res;
		logic       last;
		logic [2:0] player_mode;
		logic [3:0] track_now;
		logic [1:0] mode_stage;
	} ui_word_t;

	// One classified tick handed from front to back.
	typedef struct packed {
		logic [31:0] now;
		logic        tab;
		logic [3:0]  press;    // rising edges of the accepted change
		logic [3:0]  release_m; // falling edges of the accepted change
		logic        long_ok;  // play hold has reached long_press_ms
		logic [1:0]  stage;    // mode hold stage after this tick
		logic [1:0]  rel_cls;  // mode release class: 0 none,1 pair,2 dub,3 wifi
	} tick_t;

	function automatic logic [1:0] classify(input logic [31:0] d, input logic [15:0] p,
		input logic [15:0] u, input logic [15:0] w);
		logic [1:0] r;
		r = 2'd0;
		if (d >= {16'd0, w}) r = 2'd3;
		else if (d >= {16'd0, u}) r = 2'd2;
		else if (d >= {16'd0, p}) r = 2'd1;
		return r;
	endfunction

endpackage

@@ rtl/bumc_if.sv @@
// Valid/ready channel carrying a payload of parameterized type.
// Depends on nothing.
interface bumc_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bumc_front.sv @@
// Front part: debounce, edge detection, press timestamps, long-hold and
// mode-hold classification. Depends on bumc_pkg.
module bumc_front import bumc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic [3:0]  raw_buttons,
	input  logic        tab_present,
	input  logic [15:0] debounce_q,
	input  logic [15:0] long_q,
	input  logic [15:0] pair_q,
	input  logic [15:0] dub_q,
	input  logic [15:0] wifi_q,
	output logic        t_valid,
	input  logic        t_ready,
	output tick_t       t_data
);
	logic [3:0]  pend_q, stable_q;
	logic [31:0] pend_time_q, play_time_q, mode_time_q;
	logic [3:0]  pend_n, stable_n, press, rel;
	logic [31:0] ptime_n, play_n, mode_n;
	logic        fire;

	assign in_ready = !t_valid || t_ready;
	assign fire = in_valid && in_ready;

	always_comb begin
		pend_n = pend_q;
		ptime_n = pend_time_q;
		if (raw_buttons != pend_q) begin
			pend_n = raw_buttons;
			ptime_n = now_ms;
		end
		stable_n = stable_q;
		if (pend_n != stable_q && (now_ms - ptime_n) >= {16'd0, debounce_q})
			stable_n = pend_n;
		press = stable_n & ~stable_q;
		rel = stable_q & ~stable_n;
		play_n = press[B_PLAY] ? ptime_n : play_time_q;
		mode_n = press[B_MODE] ? ptime_n : mode_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			stable_q <= '0;
			pend_time_q <= '0;
			play_time_q <= '0;
			mode_time_q <= '0;
			t_valid <= 1'b0;
		end else begin
			if (fire) begin
				pend_q <= pend_n;
				pend_time_q <= ptime_n;
				stable_q <= stable_n;
				play_time_q <= play_n;
				mode_time_q <= mode_n;
				t_valid <= 1'b1;
				t_data.now <= now_ms;
				t_data.tab <= tab_present;
				t_data.press <= press;
				t_data.release_m <= rel;
				t_data.long_ok <= stable_n[B_PLAY] &&
					(now_ms - play_n) >= {16'd0, long_q};
				t_data.stage <= stable_n[B_MODE] ?
					classify(now_ms - mode_n, pair_q, dub_q, wifi_q) : 2'd0;
				t_data.rel_cls <= classify(now_ms - mode_time_q, pair_q, dub_q, wifi_q);
			end else if (t_ready) begin
				t_valid <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/bumc_queue.sv @@
// Short FIFO of classified ticks between front and back.
// Depends on bumc_pkg.
module bumc_queue import bumc_pkg::*; #(
	parameter int DEPTH = TICK_Q_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  w_valid,
	output logic  w_ready,
	input  tick_t w_data,
	output logic  r_valid,
	input  logic  r_ready,
	output tick_t r_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	tick_t            mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             wr, rd;

	assign w_ready = cnt_q != (AW+1)'(DEPTH);
	assign r_valid = cnt_q != '0;
	assign r_data = mem_q[rp_q];
	assign wr = w_valid && w_ready;
	assign rd = r_valid && r_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

@@ rtl/bumc_back.sv @@
// Back part: walks one tick's button edges in order, runs the player mode machine,
// emits a result word per event up to the limit, or a none word. Depends on bumc_pkg.
module bumc_back import bumc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       t_valid,
	output logic       t_ready,
	input  tick_t      t_data,
	input  logic [4:0] slots_q,
	input  logic [3:0] limit_q,
	output logic       o_valid,
	input  logic       o_ready,
	output logic [3:0] o_event,
	output logic       o_last,
	output logic [2:0] o_mode,
	output logic [3:0] o_track,
	output logic [1:0] o_stage
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_STEP = 4'b0010,
		S_EMIT = 4'b0100,
		S_DONE = 4'b1000
	} st_t;

	st_t         st_q;
	tick_t       tk_q;
	logic [2:0]  step_q;      // 0..3 buttons, 4 long-hold check
	logic [2:0]  mode_q;
	logic [3:0]  track_q, handled_q;
	logic [3:0]  ev_q [MAX_EV];
	logic [3:0]  cnt_q, rd_q, emax_q;

	// Per-step result: up to two events.
	logic [2:0]  mode_n;
	logic [3:0]  track_n, hand_n, e0, e1;
	logic        v0, v1;
	logic [4:0]  sl;
	logic [3:0]  cnt1, cnt2;
	logic        pp;

	assign pp = mode_q == M_PLAY || mode_q == M_PAUSE;
	assign sl = (slots_q == 5'd0) ? 5'd1 : (slots_q > 5'd16) ? 5'd16 : slots_q;

	function automatic logic t_data_long();
		return tk_q.long_ok && !handled_q[B_PLAY];
	endfunction

	// Remainder of x by s, five compare-and-subtract steps; s is 1..16.
	function automatic logic [3:0] wrap_slot(input logic [4:0] x, input logic [4:0] s);
		logic [5:0] r;
		r = '0;
		for (int i = 4; i >= 0; i--) begin
			r = {r[4:0], x[i]};
			if (r >= {1'b0, s}) r = r - {1'b0, s};
		end
		return r[3:0];
	endfunction

	always_comb begin
		mode_n = mode_q;
		track_n = track_q;
		hand_n = handled_q;
		e0 = E_NONE;
		e1 = E_NONE;
		v0 = 1'b0;
		v1 = 1'b0;
		if (step_q == 3'd4) begin
			if (t_data_long()) begin
				if (pp) begin e0 = E_STOP; v0 = 1'b1; end
				e1 = E_SLEEP; v1 = 1'b1;
				mode_n = M_SLEEP;
				hand_n[B_PLAY] = 1'b1;
			end
		end else if (tk_q.press[step_q[1:0]]) begin
			if (mode_q == M_SLEEP) begin
				mode_n = M_IDLE; e0 = E_WAKE; v0 = 1'b1;
				hand_n[step_q[1:0]] = 1'b1;
			end else if (mode_q == M_REC && step_q[1:0] != 2'(B_REC)) begin
				hand_n[step_q[1:0]] = 1'b1;
			end else begin
				if (mode_q == M_PAIR || mode_q == M_DUB || mode_q == M_WIFI)
					mode_n = M_IDLE;
				case (step_q[1:0])
					2'(B_REC): begin
						hand_n[B_REC] = 1'b1;
						if (!tk_q.tab) begin
							e0 = E_RREFUSE; v0 = 1'b1;
						end else begin
							if (pp) begin e0 = E_STOP; v0 = 1'b1; end
							mode_n = M_REC; e1 = E_RSTART; v1 = 1'b1;
						end
					end
					2'(B_TRACK): begin
						track_n = wrap_slot({1'b0, track_q} + 5'd1, sl);
						if (pp) begin e0 = E_STOP; v0 = 1'b1; mode_n = M_IDLE; end
						e1 = E_TRACK; v1 = 1'b1;
						hand_n[B_TRACK] = 1'b1;
					end
					default: ;
				endcase
			end
		end else if (tk_q.release_m[step_q[1:0]]) begin
			hand_n[step_q[1:0]] = 1'b0;
			case (step_q[1:0])
				2'(B_REC): begin
					if (mode_q == M_REC) begin mode_n = M_IDLE; e0 = E_RSTOP; v0 = 1'b1; end
				end
				2'(B_PLAY): begin
					if (!handled_q[B_PLAY]) begin
						v0 = 1'b1;
						if (mode_q == M_PLAY) begin mode_n = M_PAUSE; e0 = E_PAUSE; end
						else if (mode_q == M_PAUSE) begin mode_n = M_PLAY; e0 = E_RESUME; end
						else begin mode_n = M_PLAY; e0 = E_PLAY; end
					end
				end
				2'(B_MODE): begin
					if (!handled_q[B_MODE]) begin
						case (tk_q.rel_cls)
							2'd3: begin mode_n = M_WIFI; e0 = E_WIFI; v0 = 1'b1; end
							2'd2: begin mode_n = M_DUB; e0 = E_DUB; v0 = 1'b1; end
							2'd1: begin mode_n = M_PAIR; e0 = E_PAIR; v0 = 1'b1; end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
		cnt1 = (v0 && cnt_q < emax_q) ? cnt_q + 4'd1 : cnt_q;
		cnt2 = (v1 && cnt1 < emax_q) ? cnt1 + 4'd1 : cnt1;
	end

	assign t_ready = st_q == S_IDLE;
	assign o_valid = st_q == S_EMIT;
	assign o_event = (cnt_q == '0) ? E_NONE : ev_q[rd_q];
	assign o_last = (cnt_q == '0) || (rd_q + 4'd1 == cnt_q);
	assign o_mode = mode_q;
	assign o_track = track_q;
	assign o_stage = tk_q.stage;

	always_ff @(posedge clk) begin
		if (st_q == S_STEP) begin
			if (v0 && cnt_q < emax_q) ev_q[cnt_q] <= e0;
			if (v1 && cnt1 < emax_q) ev_q[cnt1] <= e1;
		end
		if (t_valid && t_ready) tk_q <= t_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			step_q <= '0;
			mode_q <= M_IDLE;
			track_q <= '0;
			handled_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
			emax_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (t_valid) begin
						st_q <= S_STEP;
						step_q <= '0;
						cnt_q <= '0;
						rd_q <= '0;
						emax_q <= (limit_q > 4'(MAX_EV)) ? 4'(MAX_EV) : limit_q;
					end
				end
				S_STEP: begin
					mode_q <= mode_n;
					track_q <= track_n;
					handled_q <= hand_n;
					cnt_q <= cnt2;
					if (step_q == 3'd4) st_q <= S_EMIT;
					else step_q <= step_q + 3'd1;
				end
				S_EMIT: begin
					if (o_ready) begin
						if (o_last) st_q <= S_IDLE;
						else rd_q <= rd_q + 4'd1;
					end
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/button_ui_mode_controller.sv @@
// Top level of the button UI mode controller: register file, front,
// tick queue and back. Depends on bumc_pkg, bumc_if and the bumc modules.
//
// Each accepted input word is one tick. The front debounces the raw mask,
// finds press/release edges and classifies play long-hold and mode hold
// times in the cycle it accepts the word, then pushes a tick summary into
// a two-entry queue. The back accepts a tick, walks the four buttons and
// the long-hold check one step per cycle, then drains its event buffer
// one result word per cycle while the receiver is ready. It takes a new
// tick only once the last word of the current one has gone. The front
// keeps accepting while the back drains, until the queue is full.
module button_ui_mode_controller import bumc_pkg::*; #(
	parameter int QUEUE_DEPTH = TICK_Q_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bumc_if.sink                  in_ch,
	bumc_if.source                out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	logic [15:0] debounce_q, long_q, pair_q, dub_q, wifi_q;
	logic [4:0]  slots_q;
	logic [3:0]  limit_q;
	tick_t       f_data, q_data;
	logic        f_valid, f_ready, q_valid, q_ready;

	// Configuration registers; hold between writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= 16'd30;
			long_q <= 16'd3000;
			pair_q <= 16'd2000;
			dub_q <= 16'd5000;
			wifi_q <= 16'd10000;
			slots_q <= 5'd4;
			limit_q <= 4'd10;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEBOUNCE: debounce_q <= cfg_wdata;
				REG_LONG: long_q <= cfg_wdata;
				REG_PAIR: pair_q <= cfg_wdata;
				REG_DUB: dub_q <= cfg_wdata;
				REG_WIFI: wifi_q <= cfg_wdata;
				REG_SLOTS: slots_q <= cfg_wdata[4:0];
				REG_LIMIT: limit_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	bumc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.now_ms(in_ch.data.now_ms), .raw_buttons(in_ch.data.raw_buttons),
		.tab_present(in_ch.data.tab_present),
		.debounce_q(debounce_q), .long_q(long_q), .pair_q(pair_q),
		.dub_q(dub_q), .wifi_q(wifi_q),
		.t_valid(f_valid), .t_ready(f_ready), .t_data(f_data)
	);

	bumc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
		.r_valid(q_valid), .r_ready(q_ready), .r_data(q_data)
	);

	bumc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.t_valid(q_valid), .t_ready(q_ready), .t_data(q_data),
		.slots_q(slots_q), .limit_q(limit_q),
		.o_valid(out_ch.valid), .o_ready(out_ch.ready),
		.o_event(out_ch.data.event_res), .o_last(out_ch.data.last),
		.o_mode(out_ch.data.player_mode), .o_track(out_ch.data.track_now),
		.o_stage(out_ch.data.mode_stage)
	);

	// A quiet tick always closes with a last word.
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.event_res == E_NONE |-> out_ch.data.last)
		else $error("none word without last");
	// Queue never overflows: front only hands over when there is room.
	a_q_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid)
		else $error("tick dropped between front and queue");
	// Mode holds steady under a stalled result word.
	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data.player_mode))
		else $error("mode changed under a stalled word");
endmodule

@@ test/tb_button_ui_mode_controller.sv @@
`timescale 1ns / 100ps
// Testbench for button_ui_mode_controller: a cycle-free predictor in a scoreboard
// class checks every result word. Depends on bumc_pkg, bumc_if and the RTL top.
module tb_button_ui_mode_controller;
	import bumc_pkg::*;

	// Track the player behind the block and hold the words each tick must yield.
	class ui_scoreboard;
		bit [15:0] deb, long_hold, pair_t, dub_t, wifi_t;
		bit [4:0]  slots;
		bit [3:0]  limit;
		bit [2:0]  mode;
		bit [3:0]  track;
		bit [3:0]  pend, stable, handled;
		bit [31:0] pend_t;
		bit [31:0] press_t [NUM_BUTTONS];
		bit [3:0]  evq [$];
		int        cap;
		ui_word_t  expected [$];
		int        mismatches;

		function new();
			deb = 30; long_hold = 3000; pair_t = 2000; dub_t = 5000; wifi_t = 10000;
			slots = 4; limit = 10;
			mode = M_IDLE; track = 0; pend = 0; stable = 0; handled = 0; pend_t = 0;
			foreach (press_t[i]) press_t[i] = 0;
			mismatches = 0;
		endfunction

		function void set_reg(bit [2:0] idx, bit [15:0] v);
			case (idx)
				REG_DEBOUNCE: deb = v;
				REG_LONG:     long_hold = v;
				REG_PAIR:     pair_t = v;
				REG_DUB:      dub_t = v;
				REG_WIFI:     wifi_t = v;
				REG_SLOTS:    slots = v[4:0];
				REG_LIMIT:    limit = v[3:0];
				default: ;
			endcase
		endfunction

		function void post(bit [3:0] e);
			if (evq.size() < cap) evq.push_back(e);
		endfunction

		function bit in_play();
			return mode == M_PLAY || mode == M_PAUSE;
		endfunction

		function void take_press(int b, bit tab);
			int n;
			if (mode == M_SLEEP) begin
				mode = M_IDLE;
				post(E_WAKE);
				handled[b] = 1;
				return;
			end
			if (mode == M_REC && b != B_REC) begin
				handled[b] = 1;
				return;
			end
			if (mode == M_PAIR || mode == M_DUB || mode == M_WIFI) mode = M_IDLE;
			if (b == B_REC) begin
				handled[b] = 1;
				if (!tab) begin
					post(E_RREFUSE);
					return;
				end
				if (in_play()) post(E_STOP);
				mode = M_REC;
				post(E_RSTART);
			end else if (b == B_TRACK) begin
				n = (slots < 1) ? 1 : (slots > 16) ? 16 : slots;
				track = 4'((track + 1) % n);
				if (in_play()) begin
					post(E_STOP);
					mode = M_IDLE;
				end
				post(E_TRACK);
				handled[b] = 1;
			end
		endfunction

		function bit [1:0] hold_class(bit [31:0] d);
			if (d >= wifi_t) return 2'd3;
			if (d >= dub_t) return 2'd2;
			if (d >= pair_t) return 2'd1;
			return 2'd0;
		endfunction

		function void take_release(int b, bit [31:0] now);
			bit done;
			done = handled[b];
			handled[b] = 0;
			if (b == B_REC) begin
				if (mode == M_REC) begin
					mode = M_IDLE;
					post(E_RSTOP);
				end
				return;
			end
			if (done) return;
			if (b == B_PLAY) begin
				if (mode == M_PLAY) begin
					mode = M_PAUSE;
					post(E_PAUSE);
				end else if (mode == M_PAUSE) begin
					mode = M_PLAY;
					post(E_RESUME);
				end else begin
					mode = M_PLAY;
					post(E_PLAY);
				end
			end else if (b == B_MODE) begin
				case (hold_class(now - press_t[B_MODE]))
					2'd3: begin mode = M_WIFI; post(E_WIFI); end
					2'd2: begin mode = M_DUB; post(E_DUB); end
					2'd1: begin mode = M_PAIR; post(E_PAIR); end
					default: ;
				endcase
			end
		endfunction

		// Advance the player by one accepted tick and queue its result words.
		function void note_tick(tick_word_t w);
			bit [3:0] chg, prev;
			bit [1:0] stage;
			ui_word_t r;
			evq.delete();
			cap = (limit > MAX_EV) ? MAX_EV : limit;
			if (w.raw_buttons != pend) begin
				pend = w.raw_buttons;
				pend_t = w.now_ms;
			end
			if (pend != stable && (w.now_ms - pend_t) >= deb) begin
				chg = pend ^ stable;
				prev = stable;
				stable = pend;
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (!chg[i]) continue;
					if (stable[i]) begin
						press_t[i] = pend_t;
						take_press(i, w.tab_present);
					end else if (prev[i]) begin
						take_release(i, w.now_ms);
					end
				end
			end
			if (stable[B_PLAY] && !handled[B_PLAY] &&
			    (w.now_ms - press_t[B_PLAY]) >= long_hold) begin
				if (in_play()) post(E_STOP);
				mode = M_SLEEP;
				post(E_SLEEP);
				handled[B_PLAY] = 1;
			end
			stage = stable[B_MODE] ? hold_class(w.now_ms - press_t[B_MODE]) : 2'd0;
			if (evq.size() == 0) evq.push_back(E_NONE);
			foreach (evq[i]) begin
				r.event_res = evq[i];
				r.last = (i == evq.size() - 1);
				r.player_mode = mode;
				r.track_now = track;
				r.mode_stage = stage;
				expected.push_back(r);
			end
		endfunction

		function void check_word(ui_word_t got);
			ui_word_t want;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = expected.pop_front();
			if (got.event_res !== want.event_res || got.last !== want.last ||
			    got.player_mode !== want.player_mode || got.track_now !== want.track_now ||
			    got.mode_stage !== want.mode_stage) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: event %0d/%0d last %0d/%0d mode %0d/%0d %s",
						want.event_res, got.event_res, want.last, got.last,
						want.player_mode, got.player_mode,
						$sformatf("track %0d/%0d stage %0d/%0d (exp/got)",
						want.track_now, got.track_now, want.mode_stage, got.mode_stage));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bumc_if #(.T(tick_word_t)) in_ch (clk);
	bumc_if #(.T(ui_word_t)) out_ch (clk);

	button_ui_mode_controller dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	ui_scoreboard sb = new();

	bit [31:0] now_t;
	bit [3:0]  raw_lvl;
	int        burst_left;
	int        cycles;
	bit        rx_hold;
	bit [7:0]  rx_pattern;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a healthy run ends far below this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("tb_button_ui_mode_controller: done, errors");
			$finish;
		end
	end

	// Receiver: stall on a rotating pattern, rerolled now and then; all-ready stretches too.
	// While rx_hold is set, drop most of the ready cycles on top.
	always @(posedge clk) begin
		if ($urandom_range(0, 31) == 0)
			rx_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
		else
			rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
		out_ch.ready <= (rx_hold && $urandom_range(0, 3) != 0) ? 1'b0 :
			(rx_pattern[0] | (rx_pattern == 8'h00));
	end

	// Sample the handshake mid-cycle, when every signal has settled.
	always @(negedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
	end

	// Send one tick word; hold valid across a burst, drop it for a random gap after.
	task automatic send_tick(input int dt, input bit [3:0] raw, input bit tab);
		tick_word_t w;
		bit fire;
		now_t = now_t + dt;
		raw_lvl = raw;
		w.now_ms = now_t;
		w.raw_buttons = raw;
		w.tab_present = tab;
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do begin
			@(negedge clk);
			fire = in_ch.ready;
			@(posedge clk);
		end while (!fire);
		sb.note_tick(w);
		burst_left--;
		if (burst_left <= 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// Drop valid and wait until every expected word has come, then let the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_regs(input bit [15:0] v [7]);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			cfg_wdata <= v[i];
			sb.set_reg(i[2:0], v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly deliberate level changes held past debounce, with noise and big time jumps.
	task automatic random_ticks(input int count, input int span);
		bit [3:0] raw;
		int dt, pick;
		raw = raw_lvl;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) raw = raw ^ (4'b1 << $urandom_range(0, 3));
			else if (pick < 40) raw = 4'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 5) dt = $urandom;
			else if (pick < 15) dt = 0;
			else dt = $urandom_range(0, span);
			send_tick(dt, raw, $urandom_range(0, 5) != 0);
			if (k == count / 2 && $urandom_range(0, 1)) drain();
		end
	endtask

	typedef struct {
		int dt;
		bit [3:0] raw;
		bit tab;
	} step_t;

	initial begin
		step_t script [$];
		bit [15:0] regs [7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		rx_hold = 0;
		rx_pattern = 8'hFF;
		cycles = 0;
		now_t = 0;
		raw_lvl = 0;
		burst_left = 4;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of every register first.
		random_ticks(30, 1500);
		drain();

		// Directed walk with short timings: most levels sent twice so they pass debounce.
		regs = '{16'd2, 16'd50, 16'd10, 16'd20, 16'd30, 16'd3, 16'd10};
		write_regs(regs);
		script = '{
			'{0, 4'h0, 1}, '{1, 4'h1, 0}, '{3, 4'h1, 0},  // record refused without tab
			'{1, 4'h0, 1}, '{3, 4'h0, 1},
			'{1, 4'h1, 1}, '{3, 4'h1, 1}, '{1, 4'h0, 1}, '{3, 4'h0, 1}, // record start, stop
			'{1, 4'h2, 1}, '{3, 4'h2, 1}, '{1, 4'h0, 1}, '{3, 4'h0, 1}, // play
			'{1, 4'h2, 1}, '{3, 4'h0, 1},                               // short glitch, filtered
			'{1, 4'h4, 1}, '{3, 4'h4, 1}, '{3, 4'h0, 1},                // track stops playback
			'{1, 4'h8, 1}, '{3, 4'h8, 1}, '{40, 4'h8, 1}, '{3, 4'h0, 1}, // long mode hold: wifi
			'{1, 4'h2, 1}, '{3, 4'h2, 1}, '{60, 4'h2, 1},               // play hold: sleep
			'{1, 4'h6, 1}, '{3, 4'h6, 1},                               // any press wakes
			'{3, 4'hF, 1}, '{3, 4'h0, 1}
		};
		foreach (script[i]) send_tick(script[i].dt, script[i].raw, script[i].tab);
		drain();

		regs = '{16'd3, 16'd60, 16'd10, 16'd25, 16'd45, 16'd5, 16'd10};
		write_regs(regs);
		random_ticks(70, 10);
		// Hold the sender off until every expected word has arrived.
		drain();

		regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		write_regs(regs);
		random_ticks(40, 4);
		drain();

		regs = '{16'd1, 16'd40, 16'd5, 16'd15, 16'd30, 16'd31, 16'd1};
		write_regs(regs);
		random_ticks(60, 8);
		drain();

		regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'd15};
		write_regs(regs);
		now_t = 32'hFFFF_0000;
		random_ticks(50, 70000);
		drain();

		// Receiver stalls hard for this stretch.
		regs = '{16'd2, 16'd30, 16'd8, 16'd16, 16'd24, 16'd1, 16'd3};
		write_regs(regs);
		now_t = $urandom;
		rx_hold = 1;
		random_ticks(70, 6);
		drain();
		rx_hold = 0;

		regs = '{16'd4, 16'd80, 16'd12, 16'd30, 16'd50, 16'd7, 16'd10};
		write_regs(regs);
		random_ticks(20, 12);
		drain();

		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("tb_button_ui_mode_controller: done, clean");
		else
			$display("tb_button_ui_mode_controller: done, errors");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/bumc_pkg.sv
rtl/bumc_if.sv
rtl/bumc_front.sv
rtl/bumc_queue.sv
rtl/bumc_back.sv
rtl/button_ui_mode_controller.sv
test/tb_button_ui_mode_controller.sv
